@@ src/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CELL_W     = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int OFF_OUT_W  = 11;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] LINE_FEED  = 8'd10;
    localparam logic [7:0] RESET_ATTR = 8'h0F;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic [10:0] read_index;
    } tcw_req_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [OFF_OUT_W-1:0] cursor_offset;
        logic [7:0]           read_char;
        logic [7:0]           read_attr;
    } tcw_result_t;

endpackage

`default_nettype wire

@@ src/text_console_writer.sv @@
// A printable character is done the cycle after acceptance, busy low; a read passes READ;
// a line feed blanks the row's tail; a scroll adds COPY, DRAIN, FILL; a clear blanks all.
// Throughput is set by the single write port of the screen store: one cell per cycle.
// Reset: cursor homes and a clearing pass of ROWS*COLUMNS cells (2000 at 80x25) fills the
// store with attribute 0x0F spaces; busy is high meanwhile. Results cannot be stalled.
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console over a character-cell screen store.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire tcw_pkg::tcw_req_t           request,
    output logic                             done,
    output tcw_pkg::tcw_result_t             result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tcw_pkg::PDATA_W-1:0] pwdata,
    output logic      [tcw_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);

    logic [7:0]        text_attribute;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    tcw_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .text_attribute (text_attribute)
    );

    tcw_screen_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .text_attribute (text_attribute),
        .done           (done),
        .result         (result),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

endmodule

`default_nettype wire

@@ src/tcw_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Character-cell screen store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/tcw_regs.sv @@
// ----------------------------------------------------------------------------
// tcw_regs
// APB register file: text attribute byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tcw_pkg::PDATA_W-1:0] pwdata,
    output logic      [tcw_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output logic      [7:0]                  text_attribute
);
    import tcw_pkg::*;

    logic [7:0] attr_reg;
    logic       sel_attr;

    assign sel_attr = (paddr[2] == REG_TEXT_ATTR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else if (psel && penable && pwrite && sel_attr)
        begin
            attr_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_attr)
        begin
            prdata = {{(PDATA_W-8){1'b0}}, attr_reg};
        end
    end

    assign pready         = 1'b1;
    assign text_attribute = attr_reg;

endmodule

`default_nettype wire

@@ src/tcw_seq.sv @@
// ----------------------------------------------------------------------------
// tcw_seq
// Sequencer: cursor state, row/screen walks and scroll copy over the store.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_seq #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    parameter int AW      = $clog2(ROWS * COLUMNS)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire tcw_pkg::tcw_req_t          request,
    input  wire logic [7:0]                 text_attribute,
    output logic                            done,
    output tcw_pkg::tcw_result_t            result,
    output logic                            mem_we,
    output logic      [AW-1:0]              mem_waddr,
    output logic      [tcw_pkg::CELL_W-1:0] mem_wdata,
    output logic      [AW-1:0]              mem_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] mem_rdata
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_BLANK,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_CLEAR
    } state_t;

    state_t            state_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [AW-1:0]     base_reg;
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     end_reg;
    logic [AW-1:0]     copy_dst_reg;
    logic              copy_valid_reg;
    logic [CELL_W-1:0] fill_cell_reg;
    logic              done_reg;
    logic [7:0]        rc_reg;
    logic [7:0]        ra_reg;

    logic [AW-1:0]     cur_addr;
    logic [CELL_W-1:0] blank;
    logic              col_last;
    logic              row_last;
    logic              in_range;
    logic              accept;

    assign cur_addr = base_reg + AW'(col_reg);
    assign blank    = {text_attribute, BLANK_CHAR};
    assign col_last = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last = (row_reg == ROW_W'(ROWS - 1));
    assign in_range = (32'(request.read_index) < 32'(CELL_COUNT));
    assign accept   = start && (state_reg == ST_IDLE);

    // write port and read address
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = fill_cell_reg;
        unique case (state_reg) inside
            ST_INIT, ST_CLEAR, ST_BLANK, ST_FILL:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                if (start && request.mode == MODE_PUT && request.char_code != LINE_FEED)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_addr;
                    mem_wdata = {text_attribute, request.char_code};
                end
            end
            ST_COPY, ST_DRAIN:
            begin
                mem_we    = copy_valid_reg;
                mem_waddr = copy_dst_reg;
                mem_wdata = mem_rdata;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_raddr = (state_reg == ST_COPY) ? ptr_reg : AW'(request.read_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            row_reg        <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            ptr_reg        <= '0;
            end_reg        <= AW'(CELL_COUNT - 1);
            copy_dst_reg   <= '0;
            copy_valid_reg <= 1'b0;
            fill_cell_reg  <= {RESET_ATTR, BLANK_CHAR};
            done_reg       <= 1'b0;
            rc_reg         <= '0;
            ra_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_INIT:
                begin
                    if (ptr_reg == end_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + AW'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        rc_reg <= '0;
                        ra_reg <= '0;
                        case (request.mode)
                            MODE_PUT:
                            begin
                                if (request.char_code == LINE_FEED)
                                begin
                                    ptr_reg       <= cur_addr;
                                    end_reg       <= base_reg + AW'(COLUMNS - 1);
                                    fill_cell_reg <= blank;
                                    state_reg     <= ST_BLANK;
                                end
                                else if (!col_last)
                                begin
                                    col_reg  <= col_reg + COL_W'(1);
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    col_reg <= '0;
                                    if (row_last)
                                    begin
                                        ptr_reg        <= AW'(COLUMNS);
                                        copy_valid_reg <= 1'b0;
                                        state_reg      <= ST_COPY;
                                    end
                                    else
                                    begin
                                        row_reg  <= row_reg + ROW_W'(1);
                                        base_reg <= base_reg + AW'(COLUMNS);
                                        done_reg <= 1'b1;
                                    end
                                end
                            end
                            MODE_READ:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= ST_READ;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                end
                            end
                            MODE_CLEAR:
                            begin
                                ptr_reg       <= '0;
                                end_reg       <= AW'(CELL_COUNT - 1);
                                fill_cell_reg <= blank;
                                row_reg       <= '0;
                                col_reg       <= '0;
                                base_reg      <= '0;
                                state_reg     <= ST_CLEAR;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    rc_reg    <= mem_rdata[7:0];
                    ra_reg    <= mem_rdata[15:8];
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_BLANK:
                begin
                    if (ptr_reg == end_reg)
                    begin
                        col_reg <= '0;
                        if (row_last)
                        begin
                            ptr_reg        <= AW'(COLUMNS);
                            copy_valid_reg <= 1'b0;
                            state_reg      <= ST_COPY;
                        end
                        else
                        begin
                            row_reg   <= row_reg + ROW_W'(1);
                            base_reg  <= base_reg + AW'(COLUMNS);
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + AW'(1);
                    end
                end
                ST_COPY:
                begin
                    // read one row ahead, write the cell in the next cycle
                    copy_valid_reg <= 1'b1;
                    copy_dst_reg   <= ptr_reg - AW'(COLUMNS);
                    if (ptr_reg == AW'(CELL_COUNT - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    copy_valid_reg <= 1'b0;
                    ptr_reg        <= AW'(CELL_COUNT - COLUMNS);
                    end_reg        <= AW'(CELL_COUNT - 1);
                    fill_cell_reg  <= blank;
                    state_reg      <= ST_FILL;
                end
                ST_FILL, ST_CLEAR:
                begin
                    if (ptr_reg == end_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + AW'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy                 = (state_reg != ST_IDLE);
    assign done                 = done_reg;
    assign result.cursor_row    = ROW_OUT_W'(row_reg);
    assign result.cursor_col    = COL_OUT_W'(col_reg);
    assign result.cursor_offset = OFF_OUT_W'(cur_addr);
    assign result.read_char     = rc_reg;
    assign result.read_attr     = ra_reg;

endmodule

`default_nettype wire

@@ src/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on request/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    logic accept;

    assign accept = start && !busy;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("request accepted without result or busy");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accept) |=> !done)
        else $error("result repeated without a request");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !done)
        else $error("result without a request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire

@@ bench/text_console_writer_test.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the text console writer. A queue of requests and
// attribute writes feeds a clocked driver. Each request is scored against a
// local model of the screen store and cursor. A clocked monitor compares every
// strobed result with the oldest predicted report. Random bursts of text, line
// feeds and reads reach row wrap and scrolling. Attribute changes happen only
// while the block is quiet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_test;

    import tcw_pkg::*;

    localparam int COLS      = DEF_COLUMNS;
    localparam int LINES     = DEF_ROWS;
    localparam int CELLS     = COLS * LINES;
    localparam int MAX_SHOWN = 10;
    localparam int TAIL_WAIT = COLS + 20;

    localparam logic [1:0]         MODE_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] ATTR_ADDR   = PADDR_W'(int'(REG_TEXT_ATTR) * 4);

    typedef enum logic [1:0] {OP_REQUEST, OP_ATTR, OP_SYNC} op_kind_e;
    typedef enum logic [1:0] {BURST_TEXT, BURST_FEED, BURST_READ} burst_e;
    typedef enum logic [2:0] {DRV_FETCH, DRV_GAP, DRV_OFFER, DRV_QUIET,
                              DRV_SETUP, DRV_ACCESS} drv_state_e;

    typedef struct {
        op_kind_e   kind;
        tcw_req_t   req;
        int         gap;
        logic [7:0] attr;
    } bus_op_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    tcw_req_t           request = '0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic               busy;
    logic               done;
    tcw_result_t        result;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    text_console_writer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // screen and cursor mirror
    logic [15:0] screen_copy [CELLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  attr_copy;

    bus_op_t     bus_ops [$];
    tcw_result_t reports_due [$];
    bus_op_t     cur_op;
    drv_state_e  drv_state = DRV_FETCH;
    int          gap_left;
    int          quiet_count;

    int     error_count;
    int     checked_count;
    int     read_count;
    int     feed_count;
    int     scroll_count;
    int     clear_count;
    int     attr_count;
    longint cycle_count = 0;
    longint cycle_limit = 64'd100_000_000;
    longint cycle_budget;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [15:0] blank_word();
        return {attr_copy, BLANK_CHAR};
    endfunction

    function automatic void shift_rows_up();
        int i;
        for (i = 0; i < CELLS - COLS; i++)
            screen_copy[i] = screen_copy[i + COLS];
        for (i = CELLS - COLS; i < CELLS; i++)
            screen_copy[i] = blank_word();
        scroll_count++;
    endfunction

    function automatic void advance_line();
        cur_col = 0;
        if (cur_row + 1 >= LINES)
        begin
            shift_rows_up();
            cur_row = LINES - 1;
        end
        else
            cur_row++;
    endfunction

    function automatic void put_char(logic [7:0] ch);
        int k;
        int base;
        base = cur_row * COLS;
        if (ch == LINE_FEED)
        begin
            for (k = cur_col; k < COLS; k++)
                screen_copy[base + k] = blank_word();
            feed_count++;
            advance_line();
        end
        else
        begin
            screen_copy[base + cur_col] = {attr_copy, ch};
            if (cur_col + 1 < COLS)
                cur_col++;
            else
                advance_line();
        end
    endfunction

    function automatic tcw_result_t console_step(tcw_req_t req);
        tcw_result_t res;
        int          i;
        int          off;
        res = '0;
        case (req.mode)
            MODE_PUT:
                put_char(req.char_code);
            MODE_READ:
            begin
                read_count++;
                if (req.read_index < CELLS)
                begin
                    res.read_char = screen_copy[req.read_index][7:0];
                    res.read_attr = screen_copy[req.read_index][15:8];
                end
            end
            MODE_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_copy[i] = blank_word();
                cur_row = 0;
                cur_col = 0;
                clear_count++;
            end
            default:
                ;
        endcase
        off = cur_row * COLS + cur_col;
        res.cursor_row    = ROW_OUT_W'(cur_row);
        res.cursor_col    = COL_OUT_W'(cur_col);
        res.cursor_offset = OFF_OUT_W'(off);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(60, 250);
    endfunction

    task automatic queue_request(logic [1:0] mode, logic [7:0] ch, logic [10:0] idx, int gap);
        bus_op_t op;
        op.kind           = OP_REQUEST;
        op.req.mode       = mode;
        op.req.char_code  = ch;
        op.req.read_index = idx;
        op.gap            = gap;
        op.attr           = '0;
        bus_ops.push_back(op);
        cycle_budget += gap + COLS + CELLS + 8;
    endtask

    task automatic queue_control(op_kind_e kind, logic [7:0] value);
        bus_op_t op;
        op.kind = kind;
        op.req  = '0;
        op.gap  = 0;
        op.attr = value;
        bus_ops.push_back(op);
        cycle_budget += 20;
    endtask

    task automatic queue_burst(int count, burst_e flavour, bit calm);
        int          n;
        int          r;
        logic [1:0]  mode;
        logic [7:0]  ch;
        logic [10:0] idx;
        for (n = 0; n < count; n++)
        begin
            r    = $urandom_range(0, 999);
            ch   = 8'($urandom_range(0, 255));
            idx  = 11'($urandom_range(0, 2047));
            mode = MODE_PUT;
            case (flavour)
                BURST_TEXT:
                begin
                    if (r < 780)
                        mode = MODE_PUT;
                    else if (r < 830)
                        ch = LINE_FEED;
                    else if (r < 960)
                        mode = MODE_READ;
                    else if (r < 990)
                        mode = MODE_UNUSED;
                    else
                        mode = MODE_CLEAR;
                end
                BURST_FEED:
                begin
                    if (r < 450)
                        ch = LINE_FEED;
                    else if (r < 800)
                        mode = MODE_PUT;
                    else if (r < 980)
                        mode = MODE_READ;
                    else
                        mode = MODE_UNUSED;
                end
                default:
                begin
                    if (r < 700)
                        mode = MODE_READ;
                    else if (r < 920)
                        mode = MODE_PUT;
                    else if (r < 980)
                        ch = LINE_FEED;
                    else
                        mode = MODE_UNUSED;
                end
            endcase
            if (mode == MODE_READ && $urandom_range(0, 9) < 8)
                idx = 11'($urandom_range(0, CELLS - 1));
            queue_request(mode, ch, idx, calm ? 0 : pick_gap());
        end
    endtask

    task automatic queue_phase(int count);
        int     len;
        int     r;
        burst_e flavour;
        while (count > 0)
        begin
            r = $urandom_range(0, 3);
            flavour = (r < 2) ? BURST_TEXT : ((r == 2) ? BURST_FEED : BURST_READ);
            len = $urandom_range(20, 60);
            if (len > count)
                len = count;
            queue_burst(len, flavour, $urandom_range(0, 3) == 0);
            count -= len;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            case (drv_state)
                DRV_FETCH:
                begin
                    if (bus_ops.size() != 0)
                    begin
                        cur_op = bus_ops.pop_front();
                        if (cur_op.kind != OP_REQUEST)
                        begin
                            quiet_count <= 0;
                            drv_state   <= DRV_QUIET;
                        end
                        else if (cur_op.gap == 0)
                        begin
                            start     <= 1'b1;
                            request   <= cur_op.req;
                            drv_state <= DRV_OFFER;
                        end
                        else
                        begin
                            gap_left  <= cur_op.gap - 1;
                            drv_state <= DRV_GAP;
                        end
                    end
                end
                DRV_GAP:
                begin
                    if (gap_left == 0)
                    begin
                        start     <= 1'b1;
                        request   <= cur_op.req;
                        drv_state <= DRV_OFFER;
                    end
                    else
                        gap_left <= gap_left - 1;
                end
                DRV_OFFER:
                begin
                    if (start && !busy)
                    begin
                        reports_due.push_back(console_step(request));
                        if (bus_ops.size() != 0 && bus_ops[0].kind == OP_REQUEST &&
                            bus_ops[0].gap == 0)
                        begin
                            cur_op = bus_ops.pop_front();
                            request <= cur_op.req;
                        end
                        else
                        begin
                            start     <= 1'b0;
                            drv_state <= DRV_FETCH;
                        end
                    end
                end
                DRV_QUIET:
                begin
                    if (reports_due.size() == 0 && !busy && !done)
                    begin
                        if (quiet_count >= 2)
                        begin
                            if (cur_op.kind == OP_ATTR)
                            begin
                                psel      <= 1'b1;
                                pwrite    <= 1'b1;
                                paddr     <= ATTR_ADDR;
                                pwdata    <= PDATA_W'(cur_op.attr);
                                drv_state <= DRV_SETUP;
                            end
                            else
                                drv_state <= DRV_FETCH;
                        end
                        else
                            quiet_count <= quiet_count + 1;
                    end
                    else
                        quiet_count <= 0;
                end
                DRV_SETUP:
                begin
                    penable   <= 1'b1;
                    drv_state <= DRV_ACCESS;
                end
                default:
                begin
                    if (psel && penable && pwrite && pready)
                    begin
                        attr_copy = pwdata[7:0];
                        attr_count++;
                        psel      <= 1'b0;
                        penable   <= 1'b0;
                        pwrite    <= 1'b0;
                        drv_state <= DRV_FETCH;
                    end
                end
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        tcw_result_t want;
        if (rst_n && done)
        begin
            if (reports_due.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_SHOWN)
                    $display("unexpected result: row %0d col %0d off %0d char %02h attr %02h",
                             result.cursor_row, result.cursor_col, result.cursor_offset,
                             result.read_char, result.read_attr);
            end
            else
            begin
                want = reports_due.pop_front();
                checked_count++;
                if (result.cursor_row !== want.cursor_row ||
                    result.cursor_col !== want.cursor_col ||
                    result.cursor_offset !== want.cursor_offset ||
                    result.read_char !== want.read_char ||
                    result.read_attr !== want.read_attr)
                begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                    begin
                        $display("mismatch at result %0d: want row %0d col %0d off %0d %s",
                                 checked_count, want.cursor_row, want.cursor_col,
                                 want.cursor_offset, "");
                        $display("    want char %02h attr %02h", want.read_char,
                                 want.read_attr);
                        $display("    got row %0d col %0d off %0d char %02h attr %02h",
                                 result.cursor_row, result.cursor_col, result.cursor_offset,
                                 result.read_char, result.read_attr);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("text_console_writer_test: errors");
            $finish;
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < CELLS; i++)
            screen_copy[i] = {RESET_ATTR, BLANK_CHAR};
        cur_row      = 0;
        cur_col      = 0;
        attr_copy    = RESET_ATTR;
        cycle_budget = 4 * CELLS + 1000;

        // reset contents, edges of the read range, unused mode, puts, line feeds and a clear
        queue_request(MODE_READ, 8'h00, 11'd0, 0);
        queue_request(MODE_READ, 8'hFF, 11'd1999, 0);
        queue_request(MODE_READ, 8'h00, 11'd2000, 1);
        queue_request(MODE_READ, 8'hFF, 11'd2047, 0);
        queue_request(MODE_UNUSED, 8'hFF, 11'h7FF, 0);
        queue_request(MODE_PUT, 8'h41, 11'h7FF, 0);
        queue_request(MODE_PUT, 8'h00, 11'd0, 0);
        queue_request(MODE_PUT, 8'hFF, 11'd0, 2);
        queue_request(MODE_PUT, LINE_FEED, 11'd0, 0);
        queue_request(MODE_READ, 8'h00, 11'd0, 0);
        queue_request(MODE_READ, 8'h00, 11'd1, 0);
        queue_request(MODE_READ, 8'h00, 11'd2, 0);
        queue_request(MODE_READ, 8'h00, 11'd79, 0);
        queue_request(MODE_READ, 8'h00, 11'd80, 0);
        queue_request(MODE_PUT, LINE_FEED, 11'd5, 0);
        queue_request(MODE_CLEAR, 8'hFF, 11'h7FF, 0);
        queue_request(MODE_READ, 8'h00, 11'd0, 0);
        queue_request(MODE_PUT, 8'h7E, 11'd0, 3);
        queue_request(MODE_UNUSED, 8'h00, 11'd0, 0);

        queue_control(OP_ATTR, 8'hFF);
        queue_phase(220);
        queue_control(OP_ATTR, 8'h00);
        queue_phase(220);
        queue_control(OP_ATTR, 8'($urandom_range(1, 254)));
        queue_phase(110);
        queue_control(OP_SYNC, 8'h00);
        queue_phase(110);
        queue_control(OP_ATTR, 8'($urandom_range(1, 254)));
        queue_phase(220);
        queue_control(OP_ATTR, RESET_ATTR);
        queue_phase(220);
        cycle_limit = 3 * cycle_budget;

        while (bus_ops.size() != 0 || drv_state != DRV_FETCH)
            @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        error_count += reports_due.size();

        $display("run: %0d results checked over %0d attribute settings, %0d reads",
                 checked_count, attr_count, read_count);
        $display("run: %0d line feeds, %0d scrolls, %0d screen clears, %0d errors",
                 feed_count, scroll_count, clear_count, error_count);
        if (error_count == 0)
            $display("text_console_writer_test: clean");
        else
            $display("text_console_writer_test: errors");
        $finish;
    end

endmodule
